### rtl/tccw_pkg.sv
package tccw_pkg;

  localparam int STORE_ROWS = 256;
  localparam int LINE_COLS  = 128;
  localparam int CELLS      = STORE_ROWS * LINE_COLS;

  localparam int ADDR_W  = $clog2(CELLS);
  localparam int COL_W   = $clog2(LINE_COLS);
  localparam int SROW_W  = $clog2(STORE_ROWS);
  localparam int ROW_W   = 12;
  localparam int GLYPH_W = 8;
  localparam int COLOR_W = 32;
  localparam int CELL_W  = GLYPH_W + COLOR_W;
  localparam int SCR_W   = 10;
  localparam int OUT_COL_W = 7;

  localparam logic [ROW_W-1:0]   ROW_MAX     = 12'd4095;
  localparam logic [SCR_W-1:0]   SCREEN_MIN  = 10'd9;
  localparam logic [SCR_W-1:0]   MARGIN_ROWS = 10'd8;
  localparam logic [SCR_W-1:0]   SCREEN_RST  = 10'd96;
  localparam logic [GLYPH_W-1:0] GLYPH_NL    = 8'd10;
  localparam logic [GLYPH_W-1:0] GLYPH_BS    = 8'd8;
  localparam logic [GLYPH_W-1:0] GLYPH_SPACE = 8'h20;
  localparam logic [GLYPH_W-1:0] GLYPH_EMPTY = 8'd0;

  typedef enum logic [1:0] {
    CMD_PUT   = 2'd0,
    CMD_SET   = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_READ  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_RUN,
    ST_READ
  } state_t;

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic [ROW_W-1:0] top;
  } cursor_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [CELL_W-1:0] data;   // colour above glyph
  } wr_req_t;

  typedef struct packed {
    logic              hit;
    logic [ADDR_W-1:0] addr;
  } rd_req_t;

endpackage

### rtl/tccw_ram.sv
module tccw_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 32768
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/tccw_cursor.sv
module tccw_cursor (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            take,
  input  tccw_pkg::cmd_t                  command,
  input  logic [tccw_pkg::GLYPH_W-1:0]    glyph_in,
  input  logic [tccw_pkg::COLOR_W-1:0]    color_in,
  input  logic [7:0]                      col_in,
  input  logic [tccw_pkg::ROW_W-1:0]      row_in,
  input  logic                            end_of_text,
  input  logic [tccw_pkg::SCR_W-1:0]      screen_rows,
  output tccw_pkg::cursor_t               cur,
  output tccw_pkg::cursor_t               nxt,
  output tccw_pkg::wr_req_t               wr,
  output tccw_pkg::rd_req_t               rd
);
  import tccw_pkg::*;

  logic [COL_W:0]   col_inc;
  logic [ROW_W-1:0] row_inc;
  logic [ROW_W-1:0] wr_row;
  logic [COL_W-1:0] wr_col;
  logic [SCR_W-1:0] sr;
  logic [SCR_W-1:0] visible;
  logic [ROW_W-1:0] top_base;
  logic [ROW_W:0]   srow;

  assign col_inc = {1'b0, cur.col} + (COL_W+1)'(1);
  assign row_inc = (cur.row == ROW_MAX) ? cur.row : cur.row + ROW_W'(1);

  always_comb begin
    nxt      = cur;
    top_base = cur.top;
    wr.en    = 1'b0;
    wr_row   = cur.row;
    wr_col   = cur.col;
    wr.data  = {color_in, glyph_in};
    case (command)
      CMD_PUT: begin
        if (glyph_in == GLYPH_NL) begin
          nxt.col = '0;
          nxt.row = row_inc;
        end else if (glyph_in == GLYPH_BS) begin
          if (cur.col != '0) begin
            nxt.col = cur.col - COL_W'(1);
            wr_col  = cur.col - COL_W'(1);
            wr.data = {color_in, GLYPH_SPACE};
            wr.en   = take && ({1'b0, cur.row} < (ROW_W+1)'(STORE_ROWS));
          end
        end else begin
          wr.en = take && ({1'b0, cur.row} < (ROW_W+1)'(STORE_ROWS));
          if (col_inc >= (COL_W+1)'(LINE_COLS)) begin
            nxt.col = '0;
            nxt.row = row_inc;
          end else begin
            nxt.col = col_inc[COL_W-1:0];
          end
        end
      end
      CMD_SET: begin
        nxt.col = ({1'b0, col_in} >= 9'(LINE_COLS)) ? COL_W'(LINE_COLS - 1)
                                                    : COL_W'(col_in);
        nxt.row = ({1'b0, row_in} >= (ROW_W+1)'(STORE_ROWS)) ? ROW_W'(STORE_ROWS - 1)
                                                              : row_in;
      end
      CMD_CLEAR: begin
        nxt.col  = '0;
        nxt.row  = '0;
        top_base = '0;
        nxt.top  = '0;
      end
      default: ;
    endcase

    // scroll follows the cursor at the end of a run of text
    sr      = (screen_rows < SCREEN_MIN) ? SCREEN_MIN : screen_rows;
    visible = sr - MARGIN_ROWS;
    if (end_of_text && command != CMD_READ) begin
      if (nxt.row >= ROW_W'(visible)) begin
        nxt.top = nxt.row - ROW_W'(visible) + ROW_W'(1);
      end else if (top_base > nxt.row) begin
        nxt.top = '0;
      end
    end

    wr.addr = ADDR_W'(wr_row[SROW_W-1:0]) * ADDR_W'(LINE_COLS) + ADDR_W'(wr_col);
  end

  assign srow    = {1'b0, cur.top} + {1'b0, row_in};
  assign rd.hit  = ({1'b0, col_in} < 9'(LINE_COLS)) && (srow < (ROW_W+1)'(STORE_ROWS));
  assign rd.addr = ADDR_W'(srow[SROW_W-1:0]) * ADDR_W'(LINE_COLS)
                 + ADDR_W'(col_in[COL_W-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cur <= '0;
    end else if (take) begin
      cur <= nxt;
    end
  end

endmodule

### rtl/text_console_cell_writer.sv
// channel  dir  tdata (low bit up)                              tuser        tlast
// s_*      in   glyph_in 8, color_in 32, col_in 8, row_in 12     command 2    end_of_text
// m_*      out  cursor_col 7, cursor_row 12, scroll_row 12,      cell_valid   -
//               glyph_out 8, color_out 32
// cfg      in   cfg_data = screen_rows, written when cfg_we is high
//
// Put, set and clear words give their result word in the cycle after acceptance;
// a read word goes through the registered cell RAM read, then the output register.
// Reset and a clear word start a sweep that zeroes all 32768 cells, one per
// cycle; s_tready stays low for the whole sweep.
// s_tready is low while a result word is held by a low m_tready.
module text_console_cell_writer (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // glyph_in, color_in, col_in, row_in
  input  logic [1:0]  s_tuser,   // command
  input  logic        s_tlast,   // end_of_text
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // cursor_col, cursor_row, scroll_row, glyph_out, color_out
  output logic [0:0]  m_tuser,   // cell_valid
  input  logic        cfg_we,
  input  logic [9:0]  cfg_data
);
  import tccw_pkg::*;

  state_t state, state_next;

  logic [SCR_W-1:0]  screen_rows;
  logic [ADDR_W-1:0] clr_cnt;
  logic              take;
  logic              load_item;
  logic              load_read;
  logic              read_hit;
  cmd_t              command;

  cursor_t cur, nxt;
  wr_req_t wr;
  rd_req_t rd;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [CELL_W-1:0] ram_wdata;
  logic [CELL_W-1:0] ram_rdata;

  logic [GLYPH_W-1:0] rd_glyph;
  logic [COLOR_W-1:0] rd_color;

  assign command = cmd_t'(s_tuser);
  assign take    = s_tvalid && s_tready;

  tccw_cursor u_cursor (
    .clk         (clk),
    .rst         (rst),
    .take        (take),
    .command     (command),
    .glyph_in    (s_tdata[7:0]),
    .color_in    (s_tdata[39:8]),
    .col_in      (s_tdata[47:40]),
    .row_in      (s_tdata[59:48]),
    .end_of_text (s_tlast),
    .screen_rows (screen_rows),
    .cur         (cur),
    .nxt         (nxt),
    .wr          (wr),
    .rd          (rd)
  );

  tccw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd.addr),
    .rdata (ram_rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_cnt == ADDR_W'(CELLS - 1)) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (take && command == CMD_READ) begin
          state_next = ST_READ;
        end else if (take && command == CMD_CLEAR) begin
          state_next = ST_CLEAR;
        end
      end
      ST_READ: begin
        state_next = ST_RUN;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  // outputs
  always_comb begin
    s_tready  = 1'b0;
    load_item = 1'b0;
    load_read = 1'b0;
    ram_we    = wr.en;
    ram_waddr = wr.addr;
    ram_wdata = wr.data;
    case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt;
        ram_wdata = '0;
      end
      ST_RUN: begin
        s_tready  = !m_tvalid || m_tready;
        load_item = take && command != CMD_READ;
      end
      ST_READ: begin
        load_read = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      clr_cnt     <= '0;
      screen_rows <= SCREEN_RST;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_cnt <= clr_cnt + ADDR_W'(1);
      end else begin
        clr_cnt <= '0;
      end
      if (cfg_we) begin
        screen_rows <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      read_hit <= rd.hit;
    end
  end

  assign rd_glyph = ram_rdata[GLYPH_W-1:0];
  assign rd_color = ram_rdata[CELL_W-1:GLYPH_W];

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_item || load_read) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_item) begin
      m_tdata <= {1'b0, COLOR_W'(0), GLYPH_W'(0), nxt.top, nxt.row,
                  OUT_COL_W'(nxt.col)};
      m_tuser <= 1'b0;
    end else if (load_read) begin
      // read word: cursor is unchanged by a read
      if (!read_hit) begin
        m_tdata <= {1'b0, COLOR_W'(0), GLYPH_W'(0), cur.top, cur.row,
                    OUT_COL_W'(cur.col)};
        m_tuser <= 1'b0;
      end else if (rd_glyph == GLYPH_EMPTY) begin
        m_tdata <= {1'b0, COLOR_W'(0), GLYPH_SPACE, cur.top, cur.row,
                    OUT_COL_W'(cur.col)};
        m_tuser <= 1'b1;
      end else begin
        m_tdata <= {1'b0, rd_color, rd_glyph, cur.top, cur.row, OUT_COL_W'(cur.col)};
        m_tuser <= 1'b1;
      end
    end
  end

endmodule
